// ===== hw/rtl/kced_pkg.sv =====
package kced_pkg;

   localparam int unsigned KEYS_DEFAULT = 4;
   localparam int unsigned PIN_W        = 4;
   localparam int unsigned KEY_IDX_W    = 2;
   localparam int unsigned FLAG_W       = 7;
   localparam int unsigned TIMER_W      = 16;
   localparam int unsigned DIV_W        = 8;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned CSR_IDX_W    = 2;

   // opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_CHECK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_DIVIDER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD = 2'd3;

   // register reset values
   localparam logic [DIV_W-1:0]   SCAN_DIVIDER_RST  = 8'd20;
   localparam logic [TIMER_W-1:0] DOUBLE_WINDOW_RST = 16'd200;
   localparam logic [TIMER_W-1:0] LONG_TIME_RST     = 16'd500;
   localparam logic [TIMER_W-1:0] REPEAT_PERIOD_RST = 16'd100;

   // flag bit positions
   localparam int unsigned F_HOLD   = 0;
   localparam int unsigned F_DOWN   = 1;
   localparam int unsigned F_UP     = 2;
   localparam int unsigned F_SINGLE = 3;
   localparam int unsigned F_DOUBLE = 4;
   localparam int unsigned F_LONG   = 5;
   localparam int unsigned F_REPEAT = 6;

   localparam logic [FLAG_W-1:0] HOLD_ONLY_MASK = 7'b000_0001;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [PIN_W-1:0]     pin_levels;
      logic [KEY_IDX_W-1:0] key_index;
      logic [FLAG_W-1:0]    flag_mask;
   } req_payload_type;

   typedef struct packed {
      logic              hit;
      logic [FLAG_W-1:0] key_flags;
   } rsp_payload_type;

   // per-key command; tick, check and clear_all are already qualified by the accepted beat
   typedef struct packed {
      logic              tick;
      logic              sample;
      logic              check;
      logic              clear_all;
      logic [FLAG_W-1:0] mask;
   } key_cmd_type;

   typedef struct packed {
      logic [TIMER_W-1:0] double_window;
      logic [TIMER_W-1:0] long_time;
      logic [TIMER_W-1:0] repeat_period;
   } window_cfg_type;

endpackage

// ===== hw/rtl/kced_key.sv =====
module kced_key (
   input  logic                           clock,
   input  logic                           reset,
   input  kced_pkg::key_cmd_type          cmd,
   input  logic                           pressed,
   input  kced_pkg::window_cfg_type       cfg,
   output logic [kced_pkg::FLAG_W-1:0]    flags,
   output logic [kced_pkg::FLAG_W-1:0]    flags_next
);

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_PRESSED   = 3'd1,
      ST_RELEASED  = 3'd2,
      ST_SECOND    = 3'd3,
      ST_REPEATING = 3'd4
   } click_state_type;

   click_state_type                  state_ff, state_in;
   logic [kced_pkg::TIMER_W-1:0]     timer_ff, timer_in, timer_dec;
   logic [kced_pkg::FLAG_W-1:0]      flags_ff, flags_in;
   logic                             sample_ff, sample_in;

   // timer counts down first, the state machine sees the decremented value
   assign timer_dec = (timer_ff == '0) ? '0 : timer_ff - 1'b1;

   always_comb begin
      state_in  = state_ff;
      timer_in  = timer_ff;
      flags_in  = flags_ff;
      sample_in = sample_ff;
      if (cmd.tick) begin
         timer_in = timer_dec;
         if (cmd.sample) begin
            sample_in = pressed;
            flags_in[kced_pkg::F_HOLD] = pressed;
            if (pressed && !sample_ff) begin
               flags_in[kced_pkg::F_DOWN] = 1'b1;
            end
            if (!pressed && sample_ff) begin
               flags_in[kced_pkg::F_UP] = 1'b1;
            end
            unique case (state_ff)
               ST_IDLE: begin
                  if (pressed) begin
                     timer_in = cfg.long_time;
                     state_in = ST_PRESSED;
                  end
               end
               ST_PRESSED: begin
                  if (!pressed) begin
                     timer_in = cfg.double_window;
                     state_in = ST_RELEASED;
                  end else if (timer_dec == '0) begin
                     timer_in = cfg.repeat_period;
                     flags_in[kced_pkg::F_LONG] = 1'b1;
                     state_in = ST_REPEATING;
                  end
               end
               ST_RELEASED: begin
                  if (pressed) begin
                     flags_in[kced_pkg::F_DOUBLE] = 1'b1;
                     state_in = ST_SECOND;
                  end else if (timer_dec == '0) begin
                     flags_in[kced_pkg::F_SINGLE] = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               ST_SECOND: begin
                  if (!pressed) begin
                     state_in = ST_IDLE;
                  end
               end
               ST_REPEATING: begin
                  if (!pressed) begin
                     state_in = ST_IDLE;
                  end else if (timer_dec == '0) begin
                     timer_in = cfg.repeat_period;
                     flags_in[kced_pkg::F_REPEAT] = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_IDLE;   // stray encodings recover at next sample
               end
            endcase
         end
      end else if (cmd.check) begin
         // hold-only mask reports but never clears
         if (((flags_ff & cmd.mask) != '0) && (cmd.mask != kced_pkg::HOLD_ONLY_MASK)) begin
            flags_in = flags_ff & ~cmd.mask;
         end
      end else if (cmd.clear_all) begin
         flags_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         timer_ff  <= '0;
         flags_ff  <= '0;
         sample_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         timer_ff  <= timer_in;
         flags_ff  <= flags_in;
         sample_ff <= sample_in;
      end
   end

   assign flags      = flags_ff;
   assign flags_next = flags_in;

endmodule

// ===== hw/rtl/key_click_event_detector.sv =====
// Key click event detector: watches up to KEYS active-low key pins (only the
// first four have pins; higher keys read as released) and turns presses into
// hold, down, up, single, double, long and repeat flags per key. A tick beat
// counts every key's window timer down and, every scan_divider-th tick,
// samples the pins and steps each key's five-state click machine. A check
// beat reports whether any masked flag of one key is set and clears those
// flags (a mask of hold alone clears nothing); a clear beat zeroes all flags.
// Every request beat yields exactly one response beat, in the next cycle.
// Throughput is one beat per clock: all per-key logic is a single
// combinational pass from the key registers to the response register, and
// the response register lets a new request in while the previous response
// is taken. req_stall is high only while a response sits stalled.
// Configuration writes are taken at any time but should be made while idle.
module key_click_event_detector #(
   parameter int unsigned KEYS = kced_pkg::KEYS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kced_pkg::req_payload_type         req_payload,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kced_pkg::rsp_payload_type         rsp_payload,
   // configuration
   input  logic                              csr_write,
   input  logic [kced_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kced_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned VIEW_KEYS = 1 << kced_pkg::KEY_IDX_W;

   // configuration registers
   logic [kced_pkg::DIV_W-1:0]   scan_divider_ff;
   kced_pkg::window_cfg_type     window_cfg_ff;

   // scan counter
   logic [kced_pkg::DIV_W-1:0]   scan_count_ff, scan_count_in, scan_count_inc;
   logic                         scan_hit;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   kced_pkg::rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic                         req_accept;
   logic                         is_tick, is_check, is_clear;

   logic [kced_pkg::FLAG_W-1:0]  key_flags [KEYS];
   logic [kced_pkg::FLAG_W-1:0]  key_flags_next [KEYS];
   // addressable view: keys past KEYS read as zero
   logic [kced_pkg::FLAG_W-1:0]  view_now [VIEW_KEYS];
   logic [kced_pkg::FLAG_W-1:0]  view_next [VIEW_KEYS];
   logic [kced_pkg::FLAG_W-1:0]  before_flags;

   // --- handshake: one output register, stall only when it is held ---
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign is_tick  = req_accept && (req_payload.opcode == kced_pkg::OP_TICK);
   assign is_check = req_accept && (req_payload.opcode == kced_pkg::OP_CHECK);
   assign is_clear = req_accept && (req_payload.opcode == kced_pkg::OP_CLEAR);

   // --- scan divider: 8-bit counter, zero divider samples every tick ---
   assign scan_count_inc = scan_count_ff + 1'b1;
   assign scan_hit       = (scan_count_inc >= scan_divider_ff);
   assign scan_count_in  = !is_tick ? scan_count_ff : (scan_hit ? '0 : scan_count_inc);

   // --- per-key units ---
   for (genvar k = 0; k < KEYS; k++) begin : g_key
      kced_pkg::key_cmd_type cmd;
      logic                  pressed;
      logic                  selected;

      if (k < kced_pkg::PIN_W) begin : g_pin
         assign pressed = ~req_payload.pin_levels[k];
      end else begin : g_nopin
         assign pressed = 1'b0;
      end

      if (k < VIEW_KEYS) begin : g_sel
         assign selected = (req_payload.key_index == kced_pkg::KEY_IDX_W'(k));
      end else begin : g_nosel
         assign selected = 1'b0;
      end

      assign cmd.tick      = is_tick;
      assign cmd.sample    = scan_hit;
      assign cmd.check     = is_check & selected;
      assign cmd.clear_all = is_clear;
      assign cmd.mask      = req_payload.flag_mask;

      kced_key u_key (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .pressed    (pressed),
         .cfg        (window_cfg_ff),
         .flags      (key_flags[k]),
         .flags_next (key_flags_next[k])
      );
   end

   for (genvar v = 0; v < VIEW_KEYS; v++) begin : g_view
      if (v < KEYS) begin : g_real
         assign view_now[v]  = key_flags[v];
         assign view_next[v] = key_flags_next[v];
      end else begin : g_absent
         assign view_now[v]  = '0;
         assign view_next[v] = '0;
      end
   end

   // tick reports flags after the update; others report before clearing
   assign before_flags = is_tick ? view_next[req_payload.key_index]
                                 : view_now[req_payload.key_index];

   always_comb begin
      rsp_valid_in   = req_accept | req_stall;
      rsp_payload_in = rsp_payload_ff;
      if (req_accept) begin
         rsp_payload_in.key_flags = before_flags;
         rsp_payload_in.hit       = is_check && ((before_flags & req_payload.flag_mask) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff                <= 1'b0;
         scan_count_ff               <= '0;
         scan_divider_ff             <= kced_pkg::SCAN_DIVIDER_RST;
         window_cfg_ff.double_window <= kced_pkg::DOUBLE_WINDOW_RST;
         window_cfg_ff.long_time     <= kced_pkg::LONG_TIME_RST;
         window_cfg_ff.repeat_period <= kced_pkg::REPEAT_PERIOD_RST;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         scan_count_ff <= scan_count_in;
         if (csr_write) begin
            unique case (csr_index)
               kced_pkg::CSR_SCAN_DIVIDER: begin
                  scan_divider_ff <= csr_data[kced_pkg::DIV_W-1:0];
               end
               kced_pkg::CSR_DOUBLE_WINDOW: begin
                  window_cfg_ff.double_window <= csr_data;
               end
               kced_pkg::CSR_LONG_TIME: begin
                  window_cfg_ff.long_time <= csr_data;
               end
               kced_pkg::CSR_REPEAT_PERIOD: begin
                  window_cfg_ff.repeat_period <= csr_data;
               end
               default: begin
               end
            endcase
         end
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hw/rtl/kced_checker.sv =====
module kced_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  kced_pkg::req_payload_type         req_payload,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  kced_pkg::rsp_payload_type         rsp_payload
);

   logic req_beat;

   assign req_beat = req_valid & ~req_stall;

   // every accepted request shows its response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_valid)
      else $error("accepted request without response");

   // requests are only held back by a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // only a check can hit
   a_hit_check_only: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_payload.opcode != kced_pkg::OP_CHECK)) |=> !rsp_payload.hit)
      else $error("hit on a non-check beat");

   // a check right after a clear sees no flags
   a_clear_then_check: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_payload.opcode == kced_pkg::OP_CLEAR)) ##1
      (req_beat && (req_payload.opcode == kced_pkg::OP_CHECK))
      |=> ((rsp_payload.key_flags == '0) && !rsp_payload.hit))
      else $error("flags survived a clear");

endmodule

bind key_click_event_detector kced_checker u_kced_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
